FILE: rtl/core/mmc_pkg.sv
// Shared types and constants for the magnetometer min/max calibrator.
// No dependencies; mmc_bounds and the top level refer to this package by scoped names.
package mmc_pkg;

	// Command codes carried with each input word.
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_START  = 2'd1,
		CMD_STOP   = 2'd2
	} cmd_t;

	// Control pulses from the sequencer to the bounds tracker.
	typedef struct packed {
		logic start;
		logic stop;
		logic sample;
	} bnd_ctl_t;

	// Width and reset value of the min_span register.
	localparam int MIN_SPAN_BITS  = 15;
	localparam int MIN_SPAN_RESET = 410;

	// Bounds after reset, before saturation to the sample range.
	localparam int RST_MIN_X = -152;
	localparam int RST_MAX_X = 1120;
	localparam int RST_MIN_Y = 1697;
	localparam int RST_MAX_Y = 3410;

endpackage

FILE: rtl/core/mmc_bounds.sv
// Calibration mode and per-axis minimum/maximum tracking for the x and y axes.
// Depends on mmc_pkg for the control struct and the reset bounds.
module mmc_bounds #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmc_pkg::bnd_ctl_t             ctl,
	input  logic signed [SAMPLE_BITS-1:0] v_x,
	input  logic signed [SAMPLE_BITS-1:0] v_y,
	output logic signed [SAMPLE_BITS-1:0] min_x,
	output logic signed [SAMPLE_BITS-1:0] max_x,
	output logic signed [SAMPLE_BITS-1:0] min_y,
	output logic signed [SAMPLE_BITS-1:0] max_y
);

	typedef enum logic [1:0] {
		CAL_OFF   = 2'd0,
		CAL_SEED  = 2'd1,
		CAL_TRACK = 2'd2
	} cal_mode_t;

	// Clamp an integer into the signed sample range.
	function automatic int sat_int(input int v);
		int hi;
		int lo;
		hi = 2 ** (SAMPLE_BITS - 1) - 1;
		lo = -(2 ** (SAMPLE_BITS - 1));
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	localparam logic signed [SAMPLE_BITS-1:0] RST_MIN_X =
		SAMPLE_BITS'(sat_int(mmc_pkg::RST_MIN_X));
	localparam logic signed [SAMPLE_BITS-1:0] RST_MAX_X =
		SAMPLE_BITS'(sat_int(mmc_pkg::RST_MAX_X));
	localparam logic signed [SAMPLE_BITS-1:0] RST_MIN_Y =
		SAMPLE_BITS'(sat_int(mmc_pkg::RST_MIN_Y));
	localparam logic signed [SAMPLE_BITS-1:0] RST_MAX_Y =
		SAMPLE_BITS'(sat_int(mmc_pkg::RST_MAX_Y));

	cal_mode_t                     mode_q;
	logic signed [SAMPLE_BITS-1:0] min_x_q;
	logic signed [SAMPLE_BITS-1:0] max_x_q;
	logic signed [SAMPLE_BITS-1:0] min_y_q;
	logic signed [SAMPLE_BITS-1:0] max_y_q;

	// Mode changes on start/stop; a sample outside CAL_OFF seeds or widens the bounds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= CAL_OFF;
			min_x_q <= RST_MIN_X;
			max_x_q <= RST_MAX_X;
			min_y_q <= RST_MIN_Y;
			max_y_q <= RST_MAX_Y;
		end else if (ctl.start) begin
			mode_q <= CAL_SEED;
		end else if (ctl.stop) begin
			mode_q <= CAL_OFF;
		end else if (ctl.sample) begin
			unique case (mode_q)
				CAL_SEED: begin
					min_x_q <= v_x;
					max_x_q <= v_x;
					min_y_q <= v_y;
					max_y_q <= v_y;
					mode_q  <= CAL_TRACK;
				end
				CAL_TRACK: begin
					if (v_x < min_x_q) begin
						min_x_q <= v_x;
					end else if (v_x > max_x_q) begin
						max_x_q <= v_x;
					end
					if (v_y < min_y_q) begin
						min_y_q <= v_y;
					end else if (v_y > max_y_q) begin
						max_y_q <= v_y;
					end
				end
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	assign min_x = min_x_q;
	assign max_x = max_x_q;
	assign min_y = min_y_q;
	assign max_y = max_y_q;

endmodule

FILE: rtl/core/mmc_div.sv
// Bit-serial restoring divider; sign-magnitude dividend, quotient clamped to the sample range.
// Computes mag * 2^(FRAC_BITS+1) / divisor, one quotient bit per cycle; uses no package items.
module mmc_div #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SAMPLE_BITS:0]          dvd_mag,
	input  logic                          dvd_neg,
	input  logic [SAMPLE_BITS:0]          divisor,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] quot
);

	localparam int DW  = SAMPLE_BITS + 1;
	localparam int NW  = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int CNW = $clog2(NW);

	localparam logic [NW-1:0] QMAX_POS = NW'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic [NW-1:0] QMAX_NEG = NW'(2 ** (SAMPLE_BITS - 1));
	localparam logic signed [SAMPLE_BITS-1:0] SMAX = SAMPLE_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = SAMPLE_BITS'(2 ** (SAMPLE_BITS - 1));

	logic [DW-1:0]  acc_q;
	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  div_q;
	logic           neg_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [DW:0] sh;
	logic [DW:0] diff;
	logic        ge;

	// One restoring step: bring in the next dividend bit, subtract if it fits.
	always_comb begin
		sh   = {acc_q, quo_q[NW-1]};
		diff = sh - {1'b0, div_q};
		ge   = (sh >= {1'b0, div_q});
	end

	// The dividend shifts out of quo_q at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				acc_q  <= '0;
				quo_q  <= {dvd_mag, {(FRAC_BITS + 1){1'b0}}};
				div_q  <= divisor;
				neg_q  <= dvd_neg;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
				quo_q <= {quo_q[NW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Apply the sign and saturate the finished quotient.
	always_comb begin
		if (neg_q) begin
			quot = (quo_q > QMAX_NEG) ? SMIN : -quo_q[SAMPLE_BITS-1:0];
		end else begin
			quot = (quo_q > QMAX_POS) ? SMAX : quo_q[SAMPLE_BITS-1:0];
		end
	end

	assign done = done_q;

endmodule

FILE: rtl/core/magnetometer_minmax_calibrator.sv
// Top level of the magnetometer hard-iron min/max calibrator.
// Depends on mmc_pkg, mmc_bounds and mmc_div.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_stall    command, raw_x, raw_y, raw_z
//   output    out        out_valid / out_stall  mag_x, mag_y, mag_z, scaled
//   config    in         cfg_valid / cfg_ready  min_span
//
// Start and stop commands are accepted while idle and change the mode directly. A sample
// passes through the update, prepare and done states; when scaling applies, the bit-serial
// divider handles x and then y between prepare and done.
// Reset clears the mode, restores the default bounds and sets min_span to 410.
// A finished word waits in the output register while the next input word is accepted;
// a sample that finishes while that register is still stalled waits until it empties.
module magnetometer_minmax_calibrator #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             command,
	input  logic signed [SAMPLE_BITS-1:0]          raw_x,
	input  logic signed [SAMPLE_BITS-1:0]          raw_y,
	input  logic signed [SAMPLE_BITS-1:0]          raw_z,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [SAMPLE_BITS-1:0]          mag_x,
	output logic signed [SAMPLE_BITS-1:0]          mag_y,
	output logic signed [SAMPLE_BITS-1:0]          mag_z,
	output logic                                   scaled,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mmc_pkg::MIN_SPAN_BITS-1:0]      min_span
);

	localparam int SB = SAMPLE_BITS;
	localparam int MSW = mmc_pkg::MIN_SPAN_BITS;
	localparam int CW = (SB + 1 > MSW) ? SB + 1 : MSW;

	localparam logic signed [SB-1:0] SMAX = SB'(2 ** (SB - 1) - 1);
	localparam logic signed [SB-1:0] SMIN = SB'(2 ** (SB - 1));
	localparam logic signed [SB+1:0] SMAX_E = (SB + 2)'(2 ** (SB - 1) - 1);
	localparam logic signed [SB+1:0] SMIN_E = (SB + 2)'(-(2 ** (SB - 1)));

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_PREP,
		S_DX_GO,
		S_DX_WAIT,
		S_DY_GO,
		S_DY_WAIT,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [MSW-1:0]         min_span_q;
	logic signed [SB-1:0]   v_x_q;
	logic signed [SB-1:0]   v_y_q;
	logic signed [SB-1:0]   v_z_q;
	logic signed [SB+1:0]   res_x_q;
	logic signed [SB+1:0]   res_y_q;
	logic [SB:0]            span_x_q;
	logic [SB:0]            span_y_q;
	logic                   scale_q;
	logic signed [SB-1:0]   fx_q;
	logic signed [SB-1:0]   fy_q;
	logic                   out_valid_q;
	logic signed [SB-1:0]   mag_x_q;
	logic signed [SB-1:0]   mag_y_q;
	logic signed [SB-1:0]   mag_z_q;
	logic                   scaled_q;

	logic                   in_acc;
	mmc_pkg::bnd_ctl_t      bnd_ctl;
	logic signed [SB-1:0]   neg_x;
	logic signed [SB-1:0]   neg_z;
	logic signed [SB-1:0]   min_x;
	logic signed [SB-1:0]   max_x;
	logic signed [SB-1:0]   min_y;
	logic signed [SB-1:0]   max_y;
	logic signed [SB:0]     sum_x;
	logic signed [SB:0]     sum_y;
	logic signed [SB+1:0]   res_x;
	logic signed [SB+1:0]   res_y;
	logic [SB:0]            span_x;
	logic [SB:0]            span_y;
	logic                   do_scale;
	logic signed [SB-1:0]   sat_x;
	logic signed [SB-1:0]   sat_y;
	logic                   div_start;
	logic signed [SB+1:0]   div_res;
	logic signed [SB+1:0]   div_res_neg;
	logic [SB:0]            div_mag;
	logic [SB:0]            div_divisor;
	logic                   div_done;
	logic signed [SB-1:0]   div_quot;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// Always ready; the user must write the register only while idle (not enforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_span_q <= MSW'(mmc_pkg::MIN_SPAN_RESET);
		end else if (cfg_valid && cfg_ready) begin
			min_span_q <= min_span;
		end
	end

	// Body-frame remap with saturated negation.
	always_comb begin
		neg_x = (raw_x == SMIN) ? SMAX : -raw_x;
		neg_z = (raw_z == SMIN) ? SMAX : -raw_z;
	end

	// Control pulses for the bounds tracker.
	always_comb begin
		bnd_ctl.start  = in_acc && (command == mmc_pkg::CMD_START);
		bnd_ctl.stop   = in_acc && (command == mmc_pkg::CMD_STOP);
		bnd_ctl.sample = (state_q == S_UPD);
	end

	mmc_bounds #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_bounds (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (bnd_ctl),
		.v_x   (v_x_q),
		.v_y   (v_y_q),
		.min_x (min_x),
		.max_x (max_x),
		.min_y (min_y),
		.max_y (max_y)
	);

	// Centring offset, span and the scaling decision from the updated bounds.
	always_comb begin
		sum_x    = (SB + 1)'(max_x) + (SB + 1)'(min_x);
		sum_y    = (SB + 1)'(max_y) + (SB + 1)'(min_y);
		res_x    = (SB + 2)'(v_x_q) - (SB + 2)'(sum_x >>> 1);
		res_y    = (SB + 2)'(v_y_q) - (SB + 2)'(sum_y >>> 1);
		span_x   = (SB + 1)'(max_x) - (SB + 1)'(min_x);
		span_y   = (SB + 1)'(max_y) - (SB + 1)'(min_y);
		do_scale = (CW'(span_x) > CW'(min_span_q)) && (CW'(span_y) > CW'(min_span_q));
	end

	// Saturated centred values for the unscaled case.
	always_comb begin
		if (res_x_q > SMAX_E) begin
			sat_x = SMAX;
		end else if (res_x_q < SMIN_E) begin
			sat_x = SMIN;
		end else begin
			sat_x = res_x_q[SB-1:0];
		end
		if (res_y_q > SMAX_E) begin
			sat_y = SMAX;
		end else if (res_y_q < SMIN_E) begin
			sat_y = SMIN;
		end else begin
			sat_y = res_y_q[SB-1:0];
		end
	end

	// Divider operands: x in the first pass, y in the second.
	always_comb begin
		div_start   = ((state_q == S_DX_GO) && scale_q) || (state_q == S_DY_GO);
		div_res     = (state_q == S_DY_GO) ? res_y_q : res_x_q;
		div_res_neg = -div_res;
		div_mag     = div_res[SB+1] ? div_res_neg[SB:0] : div_res[SB:0];
		div_divisor = (state_q == S_DY_GO) ? span_y_q : span_x_q;
	end

	mmc_div #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd_mag(div_mag),
		.dvd_neg(div_res[SB+1]),
		.divisor(div_divisor),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer with the working registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			v_x_q       <= '0;
			v_y_q       <= '0;
			v_z_q       <= '0;
			res_x_q     <= '0;
			res_y_q     <= '0;
			span_x_q    <= '0;
			span_y_q    <= '0;
			scale_q     <= 1'b0;
			fx_q        <= '0;
			fy_q        <= '0;
			out_valid_q <= 1'b0;
			mag_x_q     <= '0;
			mag_y_q     <= '0;
			mag_z_q     <= '0;
			scaled_q    <= 1'b0;
		end else begin
			// The output register fills from a finished word and empties when taken.
			if ((state_q == S_DONE) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (command == mmc_pkg::CMD_SAMPLE)) begin
						v_x_q   <= neg_x;
						v_y_q   <= neg_z;
						v_z_q   <= raw_y;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					res_x_q  <= res_x;
					res_y_q  <= res_y;
					span_x_q <= span_x;
					span_y_q <= span_y;
					scale_q  <= do_scale;
					state_q  <= S_DX_GO;
				end
				S_DX_GO: begin
					if (scale_q) begin
						state_q <= S_DX_WAIT;
					end else begin
						fx_q    <= sat_x;
						fy_q    <= sat_y;
						state_q <= S_DONE;
					end
				end
				S_DX_WAIT: begin
					if (div_done) begin
						fx_q    <= div_quot;
						state_q <= S_DY_GO;
					end
				end
				S_DY_GO: begin
					state_q <= S_DY_WAIT;
				end
				S_DY_WAIT: begin
					if (div_done) begin
						fy_q    <= div_quot;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						mag_x_q     <= fx_q;
						mag_y_q     <= fy_q;
						mag_z_q     <= v_z_q;
						scaled_q    <= scale_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign mag_x     = mag_x_q;
	assign mag_y     = mag_y_q;
	assign mag_z     = mag_z_q;
	assign scaled    = scaled_q;

endmodule
